// ===== rtl/kpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Keyed parent table package
// Shared sizes, request and status codes, and the stored entry layout.
// ----------------------------------------------------------------------------
package kpt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int DATA_W      = 32;
   localparam int ACTION_W    = 2;
   localparam int STATUS_W    = 3;

   localparam logic [ACTION_W-1:0] ACT_ADD    = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOPARENT = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd6;

   typedef struct packed {
      logic signed [DATA_W-1:0] key;
      logic signed [DATA_W-1:0] parent;
      logic        [DATA_W-1:0] payload;
   } entry_type;

endpackage

// ===== rtl/keyed_parent_table.sv =====
// ----------------------------------------------------------------------------
// Keyed parent table
// Add and find scan the stored entries with one read per cycle from the single
// entry memory; a successful delete scans them again after the last entry moves.
// One request is in work at a time; the table holds up to 16 entries.
// Reset empties the table at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module keyed_parent_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [kpt_pkg::ACTION_W-1:0]         req_action,
   input  logic signed [kpt_pkg::DATA_W-1:0]    req_key,
   input  logic signed [kpt_pkg::DATA_W-1:0]    req_parent_key,
   input  logic [kpt_pkg::DATA_W-1:0]           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [kpt_pkg::STATUS_W-1:0]         rsp_status,
   output logic                                 rsp_found,
   output logic signed [kpt_pkg::DATA_W-1:0]    rsp_found_parent,
   output logic [kpt_pkg::DATA_W-1:0]           rsp_found_payload,
   output logic [kpt_pkg::CNT_W-1:0]            rsp_entry_count
);
   import kpt_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_SCAN    = 3'd1;
   localparam logic [2:0] S_DECIDE  = 3'd2;
   localparam logic [2:0] S_MOVE_RD = 3'd3;
   localparam logic [2:0] S_MOVE_WR = 3'd4;
   localparam logic [2:0] S_CLEAR   = 3'd5;
   localparam logic [2:0] S_DONE    = 3'd6;

   entry_type mem [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] mem_raddr;
   logic [IDX_W-1:0] mem_waddr;
   entry_type mem_wdata;
   logic mem_we;

   logic [2:0] state_ff, state_in;
   logic [ACTION_W-1:0] act_ff, act_in;
   logic signed [DATA_W-1:0] key_ff, key_in;
   logic signed [DATA_W-1:0] par_ff, par_in;
   logic [DATA_W-1:0] pay_ff, pay_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] issue_ff, issue_in;
   logic rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic par_hit_ff, par_hit_in;
   logic signed [DATA_W-1:0] fpar_ff, fpar_in;
   logic [DATA_W-1:0] fpay_ff, fpay_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [CNT_W-1:0] last_cnt;

   logic rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic rsp_found_ff, rsp_found_in;
   logic signed [DATA_W-1:0] rsp_par_ff, rsp_par_in;
   logic [DATA_W-1:0] rsp_pay_ff, rsp_pay_in;
   logic [CNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   // Entry memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[mem_raddr];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign last_cnt  = count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      key_in        = key_ff;
      par_in        = par_ff;
      pay_in        = pay_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      par_hit_in    = par_hit_ff;
      fpar_in       = fpar_ff;
      fpay_in       = fpay_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_par_in    = rsp_par_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      mem_raddr     = issue_ff[IDX_W-1:0];
      mem_waddr     = rd_idx_ff;
      mem_wdata     = rd_data_ff;
      mem_we        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in     = req_action;
               key_in     = req_key;
               par_in     = req_parent_key;
               pay_in     = req_payload;
               issue_in   = '0;
               hit_in     = 1'b0;
               par_hit_in = 1'b0;
               status_in  = ST_OK;
               state_in   = S_SCAN;
               // Checks that need no table lookup finish right away.
               case (req_action)
                  ACT_ADD: begin
                     if (count_ff >= CNT_W'(TABLE_DEPTH)) begin
                        status_in = ST_FULL;
                        state_in  = S_DONE;
                     end else if (req_key == '0) begin
                        status_in = ST_ZERO;
                        state_in  = S_DONE;
                     end
                  end
                  ACT_FIND: begin
                     if (req_key == '0) begin
                        status_in = ST_ZERO;
                        state_in  = S_DONE;
                     end
                  end
                  ACT_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_DONE;
                     end else if (req_key == '0) begin
                        status_in = ST_ZERO;
                        state_in  = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_SCAN: begin
            if (rd_vld_ff) begin
               if (rd_data_ff.key == key_ff) begin
                  hit_in     = 1'b1;
                  hit_idx_in = rd_idx_ff;
                  fpar_in    = rd_data_ff.parent;
                  fpay_in    = rd_data_ff.payload;
               end
               if (rd_data_ff.key == par_ff) begin
                  par_hit_in = 1'b1;
               end
            end
            if (issue_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_W-1:0];
               issue_in  = issue_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_DONE;
            case (act_ff)
               ACT_ADD: begin
                  if (hit_ff) begin
                     status_in = ST_DUP;
                  end else if (par_ff != '0 && !par_hit_ff) begin
                     status_in = ST_NOPARENT;
                  end else begin
                     mem_we            = 1'b1;
                     mem_waddr         = count_ff[IDX_W-1:0];
                     mem_wdata.key     = key_ff;
                     mem_wdata.parent  = par_ff;
                     mem_wdata.payload = pay_ff;
                     count_in          = count_ff + CNT_W'(1);
                  end
               end
               ACT_DELETE: begin
                  if (!hit_ff) begin
                     status_in = ST_NOTFOUND;
                  end else begin
                     state_in = S_MOVE_RD;
                  end
               end
               default: ;
            endcase
         end
         S_MOVE_RD: begin
            mem_raddr = last_cnt[IDX_W-1:0];
            state_in  = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            // The last entry fills the freed slot; then links to the key are cut.
            mem_we    = 1'b1;
            mem_waddr = hit_idx_ff;
            mem_wdata = rd_data_ff;
            count_in  = last_cnt;
            issue_in  = '0;
            state_in  = S_CLEAR;
         end
         S_CLEAR: begin
            if (rd_vld_ff && rd_data_ff.parent == key_ff) begin
               mem_we           = 1'b1;
               mem_waddr        = rd_idx_ff;
               mem_wdata        = rd_data_ff;
               mem_wdata.parent = '0;
            end
            if (issue_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_W-1:0];
               issue_in  = issue_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_cnt_in    = count_ff;
               if (act_ff == ACT_FIND && status_ff == ST_OK && hit_ff) begin
                  rsp_found_in = 1'b1;
                  rsp_par_in   = fpar_ff;
                  rsp_pay_in   = fpay_ff;
               end else begin
                  rsp_found_in = 1'b0;
                  rsp_par_in   = '0;
                  rsp_pay_in   = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      key_ff        <= key_in;
      par_ff        <= par_in;
      pay_ff        <= pay_in;
      issue_ff      <= issue_in;
      rd_idx_ff     <= rd_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      par_hit_ff    <= par_hit_in;
      fpar_ff       <= fpar_in;
      fpay_ff       <= fpay_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_par_ff    <= rsp_par_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_found_parent  = rsp_par_ff;
   assign rsp_found_payload = rsp_pay_ff;
   assign rsp_entry_count   = rsp_cnt_ff;

endmodule

// ===== test/keyed_parent_table_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keyed parent table testbench
// Sends add, find, delete and unused-action requests under random gaps and response stalls.
// A scoreboard keeps its own copy of the table, predicts every response and
// checks each returned field in order.
// ----------------------------------------------------------------------------
module keyed_parent_table_test;
   import kpt_pkg::*;

   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam int RANDOM_REQUESTS = 1150;
   localparam int PHASE_LEN       = 60;
   localparam int STALL_LIMIT     = 2000;
   localparam int DRAIN_CYCLES    = 60;
   localparam int MAX_PRINTED     = 40;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic                     found;
      logic signed [DATA_W-1:0] parent;
      logic [DATA_W-1:0]        payload;
      logic [CNT_W-1:0]         entry_count;
   } table_reply_type;

   typedef enum {PHASE_FILL, PHASE_MIX, PHASE_DRAIN} phase_kind_type;
   typedef enum {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_type;

   class table_scoreboard;
      logic [DATA_W-1:0] keys [TABLE_DEPTH];
      logic [DATA_W-1:0] parents [TABLE_DEPTH];
      logic [DATA_W-1:0] payloads [TABLE_DEPTH];
      int count;
      int errors;
      table_reply_type replies_q[$];

      function new();
         count = 0;
         errors = 0;
      endfunction

      function int locate(logic [DATA_W-1:0] k);
         int hit;
         hit = -1;
         for (int i = 0; i < count; i++)
            if (keys[i] == k) hit = i;
         return hit;
      endfunction

      function void note_request(logic [ACTION_W-1:0] action, logic [DATA_W-1:0] k,
                                 logic [DATA_W-1:0] pk, logic [DATA_W-1:0] pl);
         table_reply_type r;
         int pos;
         r = '0;
         r.status = ST_OK;
         case (action)
            ACT_ADD: begin
               if (count >= TABLE_DEPTH) r.status = ST_FULL;
               else if (k == '0) r.status = ST_ZERO;
               else if (locate(k) >= 0) r.status = ST_DUP;
               else if (pk != '0 && locate(pk) < 0) r.status = ST_NOPARENT;
               else begin
                  keys[count] = k;
                  parents[count] = pk;
                  payloads[count] = pl;
                  count++;
               end
            end
            ACT_FIND: begin
               if (k == '0) r.status = ST_ZERO;
               else begin
                  pos = locate(k);
                  if (pos >= 0) begin
                     r.found = 1'b1;
                     r.parent = parents[pos];
                     r.payload = payloads[pos];
                  end
               end
            end
            ACT_DELETE: begin
               if (count == 0) r.status = ST_EMPTY;
               else if (k == '0) r.status = ST_ZERO;
               else begin
                  pos = locate(k);
                  if (pos < 0) r.status = ST_NOTFOUND;
                  else begin
                     // The last entry fills the hole, then orphans lose their link.
                     keys[pos] = keys[count-1];
                     parents[pos] = parents[count-1];
                     payloads[pos] = payloads[count-1];
                     count--;
                     for (int i = 0; i < count; i++)
                        if (parents[i] == k) parents[i] = '0;
                  end
               end
            end
            default: ;
         endcase
         r.entry_count = CNT_W'(count);
         replies_q.push_back(r);
      endfunction

      task report(string msg);
         if (errors < MAX_PRINTED) $display("MISMATCH at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_response(table_reply_type got);
         table_reply_type want;
         if (replies_q.size() == 0) begin
            report($sformatf("response with no request waiting, status %0d", got.status));
            return;
         end
         want = replies_q.pop_front();
         if (got.status !== want.status)
            report($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.found !== want.found)
            report($sformatf("found %b, expected %b", got.found, want.found));
         if (got.parent !== want.parent)
            report($sformatf("found_parent %h, expected %h", got.parent, want.parent));
         if (got.payload !== want.payload)
            report($sformatf("found_payload %h, expected %h", got.payload, want.payload));
         if (got.entry_count !== want.entry_count)
            report($sformatf("entry_count %0d, expected %0d",
                             got.entry_count, want.entry_count));
      endtask
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACTION_W-1:0]      req_action = ACT_FIND;
   logic signed [DATA_W-1:0] req_key = '0;
   logic signed [DATA_W-1:0] req_parent_key = '0;
   logic [DATA_W-1:0]        req_payload = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic                     rsp_found;
   logic signed [DATA_W-1:0] rsp_found_parent;
   logic [DATA_W-1:0]        rsp_found_payload;
   logic [CNT_W-1:0]         rsp_entry_count;

   table_scoreboard sb;
   idle_mode_type req_idle = IDLE_SOME;
   idle_mode_type rsp_idle = IDLE_SOME;
   phase_kind_type phase = PHASE_FILL;
   int idle_cycles = 0;

   keyed_parent_table dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_key           (req_key),
      .req_parent_key    (req_parent_key),
      .req_payload       (req_payload),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_found         (rsp_found),
      .rsp_found_parent  (rsp_found_parent),
      .rsp_found_payload (rsp_found_payload),
      .rsp_entry_count   (rsp_entry_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int draw_wait(idle_mode_type mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_SOME: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 16)) : 0;
         default:   return int'($urandom_range(0, 16));
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] present_key();
      return sb.keys[$urandom_range(0, sb.count - 1)];
   endfunction

   // Called at a rising edge; returns at the edge where the request is taken.
   task automatic send_request(input logic [ACTION_W-1:0] action,
                               input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] pk,
                               input logic [DATA_W-1:0] pl);
      int gap;
      gap = draw_wait(req_idle);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_key <= k;
      req_parent_key <= pk;
      req_payload <= pl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(action, k, pk, pl);
   endtask

   task automatic random_request(input phase_kind_type kind);
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0] k;
      logic [DATA_W-1:0] pk;
      int roll;
      int pick;
      roll = $urandom_range(0, 99);
      action = ACT_SPARE;
      case (kind)
         PHASE_FILL: begin
            if (roll < 82) action = ACT_ADD;
            else if (roll < 90) action = ACT_FIND;
            else if (roll < 97) action = ACT_DELETE;
         end
         PHASE_MIX: begin
            if (roll < 40) action = ACT_ADD;
            else if (roll < 70) action = ACT_FIND;
            else if (roll < 97) action = ACT_DELETE;
         end
         default: begin
            if (roll < 10) action = ACT_ADD;
            else if (roll < 25) action = ACT_FIND;
            else if (roll < 97) action = ACT_DELETE;
         end
      endcase

      // Keys mostly hit the table for find and delete, and mostly miss it for add.
      pick = $urandom_range(0, 99);
      if (pick < 3) k = '0;
      else if (action == ACT_ADD) k = (pick < 15 && sb.count > 0) ? present_key() : $urandom();
      else k = (pick < 75 && sb.count > 0) ? present_key() : $urandom();

      pick = $urandom_range(0, 99);
      if (action != ACT_ADD) pk = $urandom();
      else if (pick < 25) pk = '0;
      else if (pick < 85 && sb.count > 0) pk = present_key();
      else pk = $urandom();

      send_request(action, k, pk, $urandom());
   endtask

   initial begin
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_request(ACT_FIND, 32'h0000_0005, '0, '0);
      send_request(ACT_DELETE, 32'h0000_0005, '0, '0);
      send_request(ACT_DELETE, '0, '0, '0);
      send_request(ACT_ADD, '0, '0, 32'h1111_1111);
      send_request(ACT_ADD, 32'h7FFF_FFFF, 32'h1234_5678, 32'h2222_2222);
      send_request(ACT_ADD, 32'h7FFF_FFFF, '0, 32'hFFFF_FFFF);
      send_request(ACT_ADD, 32'h8000_0000, 32'h7FFF_FFFF, '0);
      send_request(ACT_ADD, 32'hFFFF_FFFF, 32'h8000_0000, 32'hA5A5_A5A5);
      send_request(ACT_ADD, 32'h7FFF_FFFF, '0, 32'h3333_3333);
      send_request(ACT_FIND, '0, '0, '0);
      send_request(ACT_FIND, 32'h8000_0000, '0, '0);
      send_request(ACT_FIND, 32'h0000_0001, '0, '0);
      send_request(ACT_DELETE, '0, '0, '0);
      send_request(ACT_DELETE, 32'h0000_0001, '0, '0);
      // Deleting the root must leave its child without a parent.
      send_request(ACT_DELETE, 32'h7FFF_FFFF, '0, '0);
      send_request(ACT_FIND, 32'h8000_0000, '0, '0);
      send_request(ACT_SPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ACT_ADD, 32'h0000_0001, 32'hFFFF_FFFF, 32'h5A5A_5A5A);
      send_request(ACT_FIND, 32'hFFFF_FFFF, '0, '0);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % PHASE_LEN == 0) begin
            phase = phase_kind_type'((n / PHASE_LEN) % 3);
            req_idle = idle_mode_type'($urandom_range(0, 2));
            rsp_idle = idle_mode_type'($urandom_range(0, 2));
         end
         random_request(phase);
      end
      req_valid <= 1'b0;

      while (sb.replies_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) $display("[keyed_parent_table] OK");
      else $display("[keyed_parent_table] ERROR");
      $finish;
   end

   initial begin : response_side
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait(rsp_idle);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         sb.check_response({rsp_status, rsp_found, rsp_found_parent,
                            rsp_found_payload, rsp_entry_count});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("[keyed_parent_table] ERROR");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

endmodule

// ===== keyed_parent_table.f =====
rtl/kpt_pkg.sv
rtl/keyed_parent_table.sv
test/keyed_parent_table_test.sv
